// ===== hdl/tvg_pkg.sv =====
`timescale 1ns / 1ps

package tvg_pkg;

  // Phase bits kept for the sine lookup and width of the ring and segment counters.
  localparam int SINE_TABLE_BITS = 10;
  localparam int COUNT_BITS      = 8;

  // The quarter wave covers one quadrant of the truncated phase.
  localparam int QTR_BITS    = SINE_TABLE_BITS - 2;
  localparam int QTR_ENTRIES = 1 << QTR_BITS;
  localparam int QTR_SHIFT   = 14 - QTR_BITS;

  localparam int PHASE_W  = 16;
  localparam int TRIG_W   = 16;
  localparam int MAG_W    = 15;
  localparam int RADIUS_W = 16;
  localparam int CNTREG_W = 8;
  localparam int POS_W    = 18;
  localparam int VIDX_W   = 17;
  localparam int CFG_W    = 16;
  localparam int ADDR_W   = 3;

  localparam logic [MAG_W-1:0] SINE_ONE = MAG_W'(16384);

  // Register map of the configuration port.
  typedef enum logic [ADDR_W-1:0] {
    REG_MAJOR_RADIUS = 3'd0,
    REG_MINOR_RADIUS = 3'd1,
    REG_RING_COUNT   = 3'd2,
    REG_SEG_COUNT    = 3'd3,
    REG_RING_STEP    = 3'd4,
    REG_SEG_STEP     = 3'd5
  } cfg_reg_t;

  // Sequencer steps; each step from ST_PA to ST_Z but ST_CA owns the shared multiplier for one product.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PA,
    ST_PB,
    ST_CA,
    ST_RC,
    ST_Y,
    ST_X,
    ST_Z,
    ST_OUT
  } state_t;

  typedef logic [MAG_W-1:0] qtr_table_t [QTR_ENTRIES];

  // Quarter-wave polynomial, evaluated at elaboration only.
  function automatic qtr_table_t build_qtr_table();
    qtr_table_t tbl;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned inner;
    longint unsigned s;
    for (int i = 0; i < QTR_ENTRIES; i++) begin
      t     = longint'(i) << QTR_SHIFT;
      t2    = (t * t) >> 14;
      inner = 64'd10540 - ((t2 * 64'd1188) >> 14);
      inner = 64'd25736 - ((t2 * inner) >> 14);
      s     = (t * inner) >> 14;
      if (s > 64'd16384) begin
        s = 64'd16384;
      end
      tbl[i] = MAG_W'(s);
    end
    return tbl;
  endfunction

  localparam qtr_table_t SINE_QTR = build_qtr_table();

  // Sine in Q1.14 of a 16-bit phase truncated to SINE_TABLE_BITS bits.
  function automatic logic signed [TRIG_W-1:0] sine_lookup(input logic [PHASE_W-1:0] phase);
    logic [1:0]          quad;
    logic [QTR_BITS-1:0] k;
    logic [QTR_BITS-1:0] kk;
    logic [MAG_W-1:0]    mag;
    quad = phase[15:14];
    k    = phase[13 -: QTR_BITS];
    kk   = quad[0] ? QTR_BITS'(~k + 1'b1) : k;
    if (quad[0] && (k == '0)) begin
      mag = SINE_ONE;
    end else begin
      mag = SINE_QTR[kk];
    end
    if (quad[1]) begin
      return -$signed({1'b0, mag});
    end
    return $signed({1'b0, mag});
  endfunction

endpackage

// ===== hdl/torus_vertex_generator_top.sv =====
// Torus strip vertex generator. Each word taken on the slave side requests one vertex
// (s_axis_tdata[0] set restarts the mesh at vertex 0, clear asks for the next one), and one
// result word follows on the master side carrying x, y and z in signed Q5.12, saturated,
// together with the running vertex number; tlast marks the final vertex of the mesh, after
// which the walk wraps to the start. For each ring and segment pair two vertices go out,
// first on ring r and then on ring r+1. A request is taken only while the block is idle: the
// accept cycle is followed by the eight steps of a sequencer that drives a single
// 19 by 17 bit multiplier and a single sine lookup through two phase products, the tube
// radius term, y, x and z. A result that is not taken on the master side holds the block in
// its last step until the output register frees. Configuration writes take effect at once
// and must only be made while the block is idle.
`timescale 1ns / 1ps

module torus_vertex_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [17:0] pos_x, [35:18] pos_y, [53:36] pos_z,
                                      // [70:54] vertex_index, [71] zero
  output logic        m_axis_tlast,   // last_vertex
  input  logic        cfg_we,
  input  logic [tvg_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [tvg_pkg::CFG_W-1:0]  cfg_data
);

  localparam int CB     = tvg_pkg::COUNT_BITS;
  localparam int MA_W   = 19;
  localparam int MB_W   = 17;
  localparam int PROD_W = MA_W + MB_W;
  localparam int RND_W  = PROD_W - 14;

  // Configuration registers.
  logic [tvg_pkg::RADIUS_W-1:0] major_radius;
  logic [tvg_pkg::RADIUS_W-1:0] minor_radius;
  logic [tvg_pkg::CNTREG_W-1:0] ring_count;
  logic [tvg_pkg::CNTREG_W-1:0] segment_count;
  logic [tvg_pkg::PHASE_W-1:0]  ring_phase_step;
  logic [tvg_pkg::PHASE_W-1:0]  segment_phase_step;

  // Mesh walk state.
  logic [CB-1:0]               ring_index;
  logic [CB-1:0]               segment_index;
  logic                        second_of_pair;
  logic [tvg_pkg::VIDX_W-1:0]  vertex_counter;

  // Working registers of the vertex in flight.
  logic [CB-1:0]               seg_w;
  logic [CB:0]                 ring_w;
  logic [tvg_pkg::VIDX_W-1:0]  vidx_w;
  logic                        last_w;
  logic [tvg_pkg::PHASE_W-1:0] pa;
  logic [tvg_pkg::PHASE_W-1:0] pb;
  logic signed [tvg_pkg::TRIG_W-1:0] trig;
  logic signed [PROD_W-1:0]    prod;
  logic signed [MA_W-1:0]      rad;
  logic signed [tvg_pkg::POS_W-1:0] res_x;
  logic signed [tvg_pkg::POS_W-1:0] res_y;

  tvg_pkg::state_t state;
  tvg_pkg::state_t state_next;

  logic                        in_accept;
  logic                        out_load;
  logic                        mul_en;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic [tvg_pkg::PHASE_W-1:0] trig_phase;
  logic signed [RND_W-1:0]     prod_rnd;
  logic signed [tvg_pkg::POS_W-1:0] prod_sat;

  // Index bookkeeping for the accepted request.
  logic                        restart;
  logic [CB-1:0]               ri_eff;
  logic [CB-1:0]               si_eff;
  logic                        sp_eff;
  logic [tvg_pkg::VIDX_W-1:0]  vc_eff;
  logic [CB-1:0]               rcnt;
  logic [CB-1:0]               scnt;
  logic                        seg_end;
  logic                        ring_end;
  logic                        last_now;

  // round(v / 2^14) is floor((v + 8192) / 2^14), an arithmetic shift after the bias.
  function automatic logic signed [RND_W-1:0] round_q14(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] w;
    w = v + PROD_W'(8192);
    return w[PROD_W-1:14];
  endfunction

  function automatic logic signed [tvg_pkg::POS_W-1:0] sat_pos(
    input logic signed [RND_W-1:0] v
  );
    localparam logic signed [RND_W-1:0] HI = RND_W'(131071);
    localparam logic signed [RND_W-1:0] LO = -RND_W'(131072);
    if (v > HI) begin
      return tvg_pkg::POS_W'(131071);
    end
    if (v < LO) begin
      return -tvg_pkg::POS_W'(131072);
    end
    return v[tvg_pkg::POS_W-1:0];
  endfunction

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == tvg_pkg::ST_IDLE);
  assign restart       = s_axis_tdata[0];

  assign ri_eff   = restart ? '0 : ring_index;
  assign si_eff   = restart ? '0 : segment_index;
  assign sp_eff   = restart ? 1'b0 : second_of_pair;
  assign vc_eff   = restart ? '0 : vertex_counter;
  assign rcnt     = CB'(ring_count);
  assign scnt     = CB'(segment_count);
  assign seg_end  = (si_eff >= scnt);
  assign ring_end = (ri_eff >= rcnt);
  assign last_now = seg_end && ring_end && sp_eff;

  assign prod_rnd = round_q14(prod);
  assign prod_sat = sat_pos(prod_rnd);

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      major_radius       <= tvg_pkg::RADIUS_W'(4096);
      minor_radius       <= tvg_pkg::RADIUS_W'(2048);
      ring_count         <= tvg_pkg::CNTREG_W'(30);
      segment_count      <= tvg_pkg::CNTREG_W'(20);
      ring_phase_step    <= tvg_pkg::PHASE_W'(2185);
      segment_phase_step <= tvg_pkg::PHASE_W'(3277);
    end else if (cfg_we) begin
      case (cfg_addr)
        tvg_pkg::REG_MAJOR_RADIUS: major_radius       <= cfg_data[tvg_pkg::RADIUS_W-1:0];
        tvg_pkg::REG_MINOR_RADIUS: minor_radius       <= cfg_data[tvg_pkg::RADIUS_W-1:0];
        tvg_pkg::REG_RING_COUNT:   ring_count         <= cfg_data[tvg_pkg::CNTREG_W-1:0];
        tvg_pkg::REG_SEG_COUNT:    segment_count      <= cfg_data[tvg_pkg::CNTREG_W-1:0];
        tvg_pkg::REG_RING_STEP:    ring_phase_step    <= cfg_data[tvg_pkg::PHASE_W-1:0];
        tvg_pkg::REG_SEG_STEP:     segment_phase_step <= cfg_data[tvg_pkg::PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // The walk advances as soon as a request is taken; the math then runs on the captured
  // indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_index     <= '0;
      segment_index  <= '0;
      second_of_pair <= 1'b0;
      vertex_counter <= '0;
    end else if (in_accept) begin
      second_of_pair <= !sp_eff;
      ring_index     <= ri_eff;
      segment_index  <= si_eff;
      if (sp_eff) begin
        if (seg_end) begin
          segment_index <= '0;
          ring_index    <= ring_end ? '0 : CB'(ri_eff + 1'b1);
        end else begin
          segment_index <= CB'(si_eff + 1'b1);
        end
      end
      vertex_counter <= last_now ? '0 : tvg_pkg::VIDX_W'(vc_eff + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: picks the multiplier operands and the phase for the shared sine lookup.
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    mul_en     = 1'b0;
    mul_a      = $signed({3'b000, minor_radius});
    mul_b      = MB_W'(trig);
    trig_phase = pa;
    case (state)
      tvg_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = tvg_pkg::ST_PA;
        end
      end
      tvg_pkg::ST_PA: begin
        mul_en     = 1'b1;
        mul_a      = $signed(MA_W'(seg_w));
        mul_b      = $signed({1'b0, segment_phase_step});
        state_next = tvg_pkg::ST_PB;
      end
      tvg_pkg::ST_PB: begin
        mul_en     = 1'b1;
        mul_a      = $signed(MA_W'(ring_w));
        mul_b      = $signed({1'b0, ring_phase_step});
        state_next = tvg_pkg::ST_CA;
      end
      tvg_pkg::ST_CA: begin
        trig_phase = pa + 16'h4000;
        state_next = tvg_pkg::ST_RC;
      end
      tvg_pkg::ST_RC: begin
        mul_en     = 1'b1;
        trig_phase = pa;
        state_next = tvg_pkg::ST_Y;
      end
      tvg_pkg::ST_Y: begin
        mul_en     = 1'b1;
        trig_phase = pb + 16'h4000;
        state_next = tvg_pkg::ST_X;
      end
      tvg_pkg::ST_X: begin
        mul_en     = 1'b1;
        mul_a      = rad;
        trig_phase = pb;
        state_next = tvg_pkg::ST_Z;
      end
      tvg_pkg::ST_Z: begin
        mul_en     = 1'b1;
        mul_a      = rad;
        state_next = tvg_pkg::ST_OUT;
      end
      tvg_pkg::ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = tvg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tvg_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      seg_w  <= si_eff;
      ring_w <= {1'b0, ri_eff} + (CB+1)'(sp_eff);
      vidx_w <= vc_eff;
      last_w <= last_now;
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    trig <= tvg_pkg::sine_lookup(trig_phase);
    case (state)
      tvg_pkg::ST_PB: pa    <= prod[tvg_pkg::PHASE_W-1:0];
      tvg_pkg::ST_CA: pb    <= prod[tvg_pkg::PHASE_W-1:0];
      tvg_pkg::ST_Y:  rad   <= $signed({3'b000, major_radius}) + prod_rnd[MA_W-1:0];
      tvg_pkg::ST_X:  res_y <= prod_sat;
      tvg_pkg::ST_Z:  res_x <= prod_sat;
      default: ;
    endcase
  end

  // Output register: the finished vertex waits here while the next request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, vidx_w, prod_sat, res_y, res_x};
      m_axis_tlast <= last_w;
    end
  end

endmodule

// ===== hdl/tvg_checker.sv =====
`timescale 1ns / 1ps

module tvg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Reset leaves the block ready for a request with no result pending.
  a_reset_state: assert property (@(posedge clk) rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after reset");

  // Once a request is taken the block is busy working on it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while still working");

  // A new result only appears at the end of a computation, never straight out of idle.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind torus_vertex_generator_top tvg_checker u_tvg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
